// ----- hw/rtl/imh_pkg.sv -----
// shared types and constants for the indexed min-heap block
// no dependencies; used by imh_store and indexed_min_heap_decrease_key
package imh_pkg;

  localparam int ID_BITS        = 10;
  localparam int ID_SPACE       = 1 << ID_BITS;
  localparam int IN_VALUE_BITS  = 32;
  localparam int COUNT_BITS     = 11;
  localparam int CAPACITY_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]                      mode;
    logic [ID_BITS-1:0]              item_index;
    logic signed [IN_VALUE_BITS-1:0] item_value;
  } request_t;

  typedef struct packed {
    logic [ID_BITS-1:0]              top_index;
    logic signed [IN_VALUE_BITS-1:0] top_value;
    logic [COUNT_BITS-1:0]           entry_count;
    logic                            is_empty;
    logic [1:0]                      error_code;
  } result_t;

endpackage

// ----- hw/rtl/imh_store.sv -----
// heap slot memory and position map memory, one read and one write port each
// depends on imh_pkg; read data is registered and appears in the cycle after its address
module imh_store
  import imh_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int SW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic [AW-1:0]                slot_raddr,
  output logic [ID_BITS-1:0]           slot_ridx,
  output logic signed [VALUE_BITS-1:0] slot_rval,
  input  logic                         slot_we,
  input  logic [AW-1:0]                slot_waddr,
  input  logic [ID_BITS-1:0]           slot_widx,
  input  logic signed [VALUE_BITS-1:0] slot_wval,
  input  logic [ID_BITS-1:0]           map_raddr,
  output logic [SW-1:0]                map_rdata,
  input  logic                         map_we,
  input  logic [ID_BITS-1:0]           map_waddr,
  input  logic [SW-1:0]                map_wdata
);

  logic [ID_BITS-1:0]           idx_mem [CAPACITY];
  logic signed [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [SW-1:0]                map_mem [ID_SPACE];

  always_ff @(posedge clk) begin
    if (slot_we) begin
      idx_mem[slot_waddr] <= slot_widx;
      val_mem[slot_waddr] <= slot_wval;
    end
    slot_ridx <= idx_mem[slot_raddr];
    slot_rval <= val_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata <= map_mem[map_raddr];
  end

endmodule

// ----- hw/rtl/indexed_min_heap_decrease_key.sv -----
// indexed binary min-heap with decrease-key, top level and sequencer
// depends on imh_pkg and imh_store
//
// usage: present a request and raise start; it is taken at a clock edge with
// start high and busy low. mode push inserts an absent identifier or lowers
// the value of a present one, pop removes the minimum, clear empties the heap.
// exactly one result follows each request: it sits on result for one cycle
// with done high and is taken at the edge that ends that cycle; the receiver
// cannot stall, and a new request may be taken in that same cycle.
// push looks up the position map, reads the slot it names when the identifier
// may be held, and climbs the entry level by level toward the root (the parent
// read overlaps the write-back); pop moves the last entry to the root and
// sifts it down until it settles at a leaf or a compare stops it (two child
// reads and a compare per level through the single slot read port). clear and
// pop on an empty heap go straight to the result, and so do push into a full
// heap and push of a value that is not smaller. one request is in flight at
// a time. after reset the block sweeps the position map to zero, one entry a
// cycle, with busy high; the heap is then empty.
module indexed_min_heap_decrease_key
  import imh_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);

  typedef enum logic [11:0] {
    S_INIT = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_PCHK = 12'b000000000100,
    S_PVER = 12'b000000001000,
    S_UP   = 12'b000000010000,
    S_UCMP = 12'b000000100000,
    S_POPQ = 12'b000001000000,
    S_DN   = 12'b000010000000,
    S_DLQ  = 12'b000100000000,
    S_DRQ  = 12'b001000000000,
    S_FIN  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_t;

  state_t                       state, state_next;
  logic [SW-1:0]                count, count_next;
  logic [SW-1:0]                pos, pos_next;
  logic [ID_BITS-1:0]           cur_idx, cur_idx_next;
  logic signed [VALUE_BITS-1:0] cur_val, cur_val_next;
  logic [ID_BITS-1:0]           left_idx, left_idx_next;
  logic signed [VALUE_BITS-1:0] left_val, left_val_next;
  logic [1:0]                   err, err_next;
  logic [ID_BITS-1:0]           top_idx;
  logic signed [VALUE_BITS-1:0] top_val;
  logic [ID_BITS-1:0]           init_ptr;
  logic                         done_next;
  result_t                      result_next;

  // store ports, slots addressed by heap position 1..CAPACITY
  logic [SW-1:0]                rd_slot, wr_slot, rd_m1, wr_m1;
  logic [ID_BITS-1:0]           slot_ridx, slot_widx;
  logic signed [VALUE_BITS-1:0] slot_rval, slot_wval;
  logic                         slot_we;
  logic [ID_BITS-1:0]           map_raddr, map_waddr;
  logic [SW-1:0]                map_rdata, map_wdata;
  logic                         map_we;

  logic signed [63:0]           in_wide, top_wide;
  logic signed [VALUE_BITS-1:0] in_val;
  logic [SW:0]                  child, child_r;
  logic                         pick_right;
  logic [ID_BITS-1:0]           ch_idx;
  logic signed [VALUE_BITS-1:0] ch_val;
  logic [SW-1:0]                ch_pos;

  assign in_wide  = 64'(request.item_value);
  assign in_val   = in_wide[VALUE_BITS-1:0];
  assign top_wide = 64'(top_val);
  assign rd_m1    = rd_slot - SW'(1);
  assign wr_m1    = wr_slot - SW'(1);
  assign child    = {pos, 1'b0};
  assign child_r  = child + (SW+1)'(1);
  assign busy     = (state != S_IDLE);

  imh_store #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk        (clk),
    .slot_raddr (rd_m1[AW-1:0]),
    .slot_ridx  (slot_ridx),
    .slot_rval  (slot_rval),
    .slot_we    (slot_we),
    .slot_waddr (wr_m1[AW-1:0]),
    .slot_widx  (slot_widx),
    .slot_wval  (slot_wval),
    .map_raddr  (map_raddr),
    .map_rdata  (map_rdata),
    .map_we     (map_we),
    .map_waddr  (map_waddr),
    .map_wdata  (map_wdata)
  );

  // child choice for sift down: right only when strictly smaller than left
  always_comb begin
    pick_right = (state == S_DRQ) && (slot_rval < left_val);
    if (state == S_DRQ) begin
      ch_idx = pick_right ? slot_ridx : left_idx;
      ch_val = pick_right ? slot_rval : left_val;
      ch_pos = pick_right ? child_r[SW-1:0] : child[SW-1:0];
    end else begin
      ch_idx = slot_ridx;
      ch_val = slot_rval;
      ch_pos = child[SW-1:0];
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    cur_idx_next  = cur_idx;
    cur_val_next  = cur_val;
    left_idx_next = left_idx;
    left_val_next = left_val;
    err_next      = err;
    done_next     = 1'b0;
    result_next   = result;
    rd_slot       = pos;
    wr_slot       = pos;
    slot_we       = 1'b0;
    slot_widx     = cur_idx;
    slot_wval     = cur_val;
    map_raddr     = request.item_index;
    map_we        = 1'b0;
    map_waddr     = cur_idx;
    map_wdata     = pos;

    unique case (state)
      S_INIT: begin
        map_we    = 1'b1;
        map_waddr = init_ptr;
        map_wdata = '0;
        if (init_ptr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          err_next = ERR_OK;
          unique case (request.mode)
            MODE_PUSH: begin
              cur_idx_next = request.item_index;
              cur_val_next = in_val;
              state_next   = S_PCHK;
            end
            MODE_POP: begin
              if (count == '0) begin
                err_next   = ERR_EMPTY;
                state_next = S_DONE;
              end else begin
                rd_slot    = count;
                count_next = count - SW'(1);
                state_next = S_POPQ;
              end
            end
            MODE_CLEAR: begin
              count_next = '0;
              state_next = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_PCHK: begin
        // a map entry counts only if the slot it names still holds this id
        if (map_rdata != '0 && map_rdata <= count) begin
          rd_slot    = map_rdata;
          pos_next   = map_rdata;
          state_next = S_PVER;
        end else if (count == SW'(CAPACITY)) begin
          err_next   = ERR_FULL;
          state_next = S_DONE;
        end else begin
          count_next = count + SW'(1);
          pos_next   = count + SW'(1);
          state_next = S_UP;
        end
      end
      S_PVER: begin
        if (slot_ridx == cur_idx) begin
          state_next = (cur_val < slot_rval) ? S_UP : S_DONE;
        end else if (count == SW'(CAPACITY)) begin
          err_next   = ERR_FULL;
          state_next = S_DONE;
        end else begin
          count_next = count + SW'(1);
          pos_next   = count + SW'(1);
          state_next = S_UP;
        end
      end
      S_UP: begin
        if (pos == SW'(1)) begin
          state_next = S_FIN;
        end else begin
          rd_slot    = pos >> 1;
          state_next = S_UCMP;
        end
      end
      S_UCMP: begin
        // parent moves down into the hole, the parent read for the next level
        // overlaps this write
        if (cur_val < slot_rval) begin
          slot_we   = 1'b1;
          slot_widx = slot_ridx;
          slot_wval = slot_rval;
          map_we    = 1'b1;
          map_waddr = slot_ridx;
          pos_next  = pos >> 1;
          rd_slot   = pos >> 2;
          if ((pos >> 1) == SW'(1)) begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_POPQ: begin
        cur_idx_next = slot_ridx;
        cur_val_next = slot_rval;
        pos_next     = SW'(1);
        state_next   = (count == '0) ? S_DONE : S_DN;
      end
      S_DN: begin
        if (child > {1'b0, count}) begin
          state_next = S_FIN;
        end else begin
          rd_slot    = child[SW-1:0];
          state_next = S_DLQ;
        end
      end
      S_DLQ, S_DRQ: begin
        if (state == S_DLQ && child < {1'b0, count}) begin
          left_idx_next = slot_ridx;
          left_val_next = slot_rval;
          rd_slot       = child_r[SW-1:0];
          state_next    = S_DRQ;
        end else if (ch_val < cur_val) begin
          slot_we    = 1'b1;
          slot_widx  = ch_idx;
          slot_wval  = ch_val;
          map_we     = 1'b1;
          map_waddr  = ch_idx;
          pos_next   = ch_pos;
          state_next = S_DN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        slot_we    = 1'b1;
        map_we     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        done_next               = 1'b1;
        result_next.top_index   = (count != '0) ? top_idx : '0;
        result_next.top_value   = (count != '0) ? top_wide[IN_VALUE_BITS-1:0] : '0;
        result_next.entry_count = COUNT_BITS'(count);
        result_next.is_empty    = (count == '0);
        result_next.error_code  = err;
        state_next              = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      count    <= '0;
      init_ptr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      done     <= done_next;
      if (state == S_INIT) begin
        init_ptr <= init_ptr + ID_BITS'(1);
      end
    end
  end

  // the root is mirrored in registers so the result needs no extra read
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cur_idx  <= cur_idx_next;
    cur_val  <= cur_val_next;
    left_idx <= left_idx_next;
    left_val <= left_val_next;
    err      <= err_next;
    result   <= result_next;
    if (slot_we && wr_slot == SW'(1)) begin
      top_idx <= slot_widx;
      top_val <= slot_wval;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= SW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_from_seq: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE))
    else $error("result strobe without a finished request");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_full_err: assert property (@(posedge clk) disable iff (rst)
    (done && result.error_code == ERR_FULL) |-> count == SW'(CAPACITY))
    else $error("full error reported with free slots");

endmodule
